// ===== rtl/strip_fan_index_assembler_core_defines.svh =====
// Assertion macros shared by the strip/fan index assembler.
// Simulation builds get the checks; synthesis builds define SYNTH and get empty bodies.
`ifndef STRIP_FAN_INDEX_ASSEMBLER_CORE_DEFINES_SVH
`define STRIP_FAN_INDEX_ASSEMBLER_CORE_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define SFIA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfia assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFIA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfia assertion failed");

`else

`define SFIA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SFIA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/sfia_pkg.sv =====
package sfia_pkg;

  // Field widths.
  localparam int WordW  = 16;
  localparam int ScaleW = 17;
  localparam int SlotW  = 13;
  localparam int RefW   = 15;
  localparam int TexW   = 32;
  localparam int CountW = 15;
  localparam int VertW  = 14;

  // Default vertex limit and the span of the slot field.
  localparam int MaxVertsDefault = 8192;
  localparam int SlotSpan        = 8192;

  // Scale value that means one in unsigned Q1.16.
  localparam logic [ScaleW-1:0] ScaleOne = 17'h10000;

  // Last word slot of a vertex and run-start vertices that give a single index.
  localparam logic [1:0]        LastWordSlot  = 2'd3;
  localparam logic [CountW-1:0] FirstSingles  = 15'd3;
  localparam logic [CountW-1:0] RunCountMax   = 15'h7FFF;

  // Record queue depth.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // Configuration register indexes.
  localparam logic CfgUScale = 1'b0;
  localparam logic CfgVScale = 1'b1;

  // One queued record: a completed vertex with its one or three indices,
  // or the list terminator.
  typedef struct packed {
    logic                    three;
    logic [SlotW-1:0]        idx0;
    logic [SlotW-1:0]        idx1;
    logic [SlotW-1:0]        idx2;
    logic [SlotW-1:0]        slot;
    logic [RefW-1:0]         pos;
    logic [RefW-1:0]         nrm;
    logic signed [TexW-1:0]  tex_u;
    logic signed [TexW-1:0]  tex_v;
    logic                    list_end;
    logic [CountW-1:0]       total_first;
    logic                    overflow;
  } rec_t;

endpackage

// ===== rtl/sfia_decode.sv =====
module sfia_decode #(
  parameter int MAX_VERTS = sfia_pkg::MaxVertsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [sfia_pkg::ScaleW-1:0]      cfg_data,
  input  logic                             accept,
  input  logic signed [sfia_pkg::WordW-1:0] word,
  output logic                             push,
  output sfia_pkg::rec_t                   rec
);

  localparam int VertLimitI = (MAX_VERTS < sfia_pkg::SlotSpan) ? MAX_VERTS
                                                               : sfia_pkg::SlotSpan;
  localparam logic [sfia_pkg::VertW-1:0] VertLimit = sfia_pkg::VertW'(VertLimitI);

  // Scale registers, saturated to one on write.
  logic [sfia_pkg::ScaleW-1:0] u_scale;
  logic [sfia_pkg::ScaleW-1:0] v_scale;
  logic [sfia_pkg::ScaleW-1:0] cfg_sat;

  assign cfg_sat = (cfg_data > sfia_pkg::ScaleOne) ? sfia_pkg::ScaleOne : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      u_scale <= sfia_pkg::ScaleOne;
      v_scale <= sfia_pkg::ScaleOne;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfia_pkg::CfgUScale: u_scale <= cfg_sat;
        sfia_pkg::CfgVScale: v_scale <= cfg_sat;
        default: ;
      endcase
    end
  end

  // Parser state.
  logic                         in_run, in_run_next;
  logic                         is_strip, is_strip_next;
  logic [sfia_pkg::CountW-1:0]  run_left, run_left_next;
  logic [sfia_pkg::CountW-1:0]  vertex_in_run, vertex_in_run_next;
  logic [1:0]                   word_slot, word_slot_next;
  logic [sfia_pkg::SlotW-1:0]   run_start_slot, run_start_slot_next;
  logic [sfia_pkg::VertW-1:0]   vertex_count, vertex_count_next;
  logic [sfia_pkg::CountW-1:0]  index_count, index_count_next;
  logic                         dropped, dropped_next;

  // First three words of the vertex being read.
  logic [sfia_pkg::RefW-1:0]    held_pos;
  logic [sfia_pkg::RefW-1:0]    held_nrm;
  logic signed [sfia_pkg::WordW-1:0] held_s;

  // Texture products: signed word times unsigned scale, low 32 bits kept.
  logic signed [33:0] prod_u;
  logic signed [33:0] prod_v;

  assign prod_u = held_s * $signed({1'b0, u_scale});
  assign prod_v = word * $signed({1'b0, v_scale});

  logic [sfia_pkg::WordW-1:0]   mag;
  logic [sfia_pkg::CountW-1:0]  vir_inc;
  logic [sfia_pkg::SlotW-1:0]   n;

  assign mag     = word[15] ? (~word + 16'd1) : word;
  assign vir_inc = (vertex_in_run < sfia_pkg::RunCountMax) ? vertex_in_run + 15'd1
                                                           : vertex_in_run;
  assign n       = vertex_count[sfia_pkg::SlotW-1:0];

  // Next state and record for the accepted word.
  always_comb begin
    in_run_next         = in_run;
    is_strip_next       = is_strip;
    run_left_next       = run_left;
    vertex_in_run_next  = vertex_in_run;
    word_slot_next      = word_slot;
    run_start_slot_next = run_start_slot;
    vertex_count_next   = vertex_count;
    index_count_next    = index_count;
    dropped_next        = dropped;
    push                = 1'b0;
    rec                 = '0;

    if (accept) begin
      if (!in_run) begin
        if (word == '0) begin
          // Terminator closes the list.
          push                = 1'b1;
          rec.list_end        = 1'b1;
          rec.total_first     = index_count;
          rec.overflow        = dropped;
          vertex_count_next   = '0;
          index_count_next    = '0;
          run_start_slot_next = '0;
          dropped_next        = 1'b0;
        end else begin
          // Header opens a strip or fan run.
          is_strip_next       = !word[15];
          run_left_next       = (mag == 16'h8000) ? sfia_pkg::RunCountMax : mag[14:0];
          vertex_in_run_next  = '0;
          word_slot_next      = '0;
          run_start_slot_next = n;
          in_run_next         = 1'b1;
        end
      end else if (word_slot != sfia_pkg::LastWordSlot) begin
        word_slot_next = word_slot + 2'd1;
      end else begin
        // Fourth word completes the vertex.
        word_slot_next     = '0;
        run_left_next      = (run_left != '0) ? run_left - 15'd1 : '0;
        in_run_next        = (run_left_next != '0);
        vertex_in_run_next = vir_inc;
        if (vertex_count >= VertLimit) begin
          dropped_next = 1'b1;
        end else begin
          push         = 1'b1;
          rec.slot     = n;
          rec.pos      = held_pos;
          rec.nrm      = held_nrm;
          rec.tex_u    = prod_u[31:0];
          rec.tex_v    = prod_v[31:0];
          rec.overflow = dropped;
          rec.total_first = index_count + 15'd1;
          rec.idx2     = n;
          if (vertex_in_run < sfia_pkg::FirstSingles) begin
            rec.three        = 1'b0;
            rec.idx0         = n;
            index_count_next = index_count + 15'd1;
          end else begin
            rec.three        = 1'b1;
            index_count_next = index_count + 15'd3;
            if (!is_strip) begin
              rec.idx0 = run_start_slot;
              rec.idx1 = n - 13'd1;
            end else if (!vertex_in_run[0]) begin
              rec.idx0 = n - 13'd2;
              rec.idx1 = n - 13'd1;
            end else begin
              rec.idx0 = n - 13'd1;
              rec.idx1 = n - 13'd2;
            end
          end
          vertex_count_next = vertex_count + 14'd1;
        end
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run         <= 1'b0;
      is_strip       <= 1'b0;
      run_left       <= '0;
      vertex_in_run  <= '0;
      word_slot      <= '0;
      run_start_slot <= '0;
      vertex_count   <= '0;
      index_count    <= '0;
      dropped        <= 1'b0;
    end else begin
      in_run         <= in_run_next;
      is_strip       <= is_strip_next;
      run_left       <= run_left_next;
      vertex_in_run  <= vertex_in_run_next;
      word_slot      <= word_slot_next;
      run_start_slot <= run_start_slot_next;
      vertex_count   <= vertex_count_next;
      index_count    <= index_count_next;
      dropped        <= dropped_next;
    end
  end

  // Vertex words are held until the fourth word arrives.
  always_ff @(posedge clk) begin
    if (accept && in_run) begin
      case (word_slot)
        2'd0:    held_pos <= word[14:0];
        2'd1:    held_nrm <= word[14:0];
        2'd2:    held_s   <= word;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/sfia_queue.sv =====
module sfia_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  sfia_pkg::rec_t                   push_rec,
  input  logic                             pop,
  output sfia_pkg::rec_t                   head,
  output logic                             head_valid,
  output logic                             full,
  output logic [sfia_pkg::QueuePtrW:0]     count
);

  sfia_pkg::rec_t                  entries [sfia_pkg::QueueDepth];
  logic [sfia_pkg::QueuePtrW-1:0]  wr_ptr;
  logic [sfia_pkg::QueuePtrW-1:0]  rd_ptr;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == (sfia_pkg::QueuePtrW+1)'(sfia_pkg::QueueDepth));

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

// ===== rtl/sfia_serial.sv =====
module sfia_serial (
  input  logic                              clk,
  input  logic                              rst,
  input  sfia_pkg::rec_t                    head,
  input  logic                              head_valid,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sfia_pkg::SlotW-1:0]        tri_index,
  output logic [sfia_pkg::SlotW-1:0]        vertex_slot,
  output logic [sfia_pkg::RefW-1:0]         position_ref,
  output logic [sfia_pkg::RefW-1:0]         normal_ref,
  output logic signed [sfia_pkg::TexW-1:0]  tex_u,
  output logic signed [sfia_pkg::TexW-1:0]  tex_v,
  output logic                              last,
  output logic                              list_end,
  output logic [sfia_pkg::CountW-1:0]       index_total,
  output logic                              overflow
);

  // Index of the next result within the head record.
  logic [1:0]                  k;
  logic                        load;
  logic                        last_sel;
  logic [sfia_pkg::SlotW-1:0]  idx_sel;

  assign load     = head_valid && (!out_valid || !out_stall);
  assign last_sel = !head.three || (k == 2'd2);
  assign pop      = load && last_sel;

  always_comb begin
    case (k)
      2'd0:    idx_sel = head.idx0;
      2'd1:    idx_sel = head.idx1;
      default: idx_sel = head.idx2;
    endcase
  end

  // Result counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= head_valid;
      end
      if (load) begin
        k <= last_sel ? 2'd0 : k + 2'd1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      tri_index    <= idx_sel;
      vertex_slot  <= head.slot;
      position_ref <= head.pos;
      normal_ref   <= head.nrm;
      tex_u        <= head.tex_u;
      tex_v        <= head.tex_v;
      last         <= last_sel;
      list_end     <= head.list_end;
      index_total  <= head.total_first + sfia_pkg::CountW'(k);
      overflow     <= head.overflow;
    end
  end

endmodule

// ===== rtl/strip_fan_index_assembler_core.sv =====
// Strip/fan index assembler.
// Input channel (in_valid, in_stall, word) takes one signed command word per
// transfer: a run header (positive count for a strip, negative for a fan), four
// words per vertex, or a zero terminator that closes the list.
// Output channel (out_valid, out_stall and the result fields) gives one index
// per transfer with its vertex record; a stored vertex gives one or three
// results (none past MAX_VERTS), the terminator one result with list_end set.
// Configuration port (cfg_we, cfg_index, cfg_data) writes the u and v scale
// registers; write them only while the block is idle.
// The first result of a word is written into the record queue on transfer and
// then loaded into the output register behind any earlier results.
// Throughput: one word per cycle in while in_stall is low and one result per
// cycle out while out_stall is low; a four-entry record queue between the parser
// and the output register absorbs the three results of a vertex, so in_stall
// rises only when that queue is full. A stalled receiver holds the output
// register; words keep flowing until the queue fills. Reset clears the parser,
// the queue and the output valid, and sets both scales to one.
`include "strip_fan_index_assembler_core_defines.svh"

module strip_fan_index_assembler_core #(
  parameter int MAX_VERTS = sfia_pkg::MaxVertsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [sfia_pkg::ScaleW-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sfia_pkg::WordW-1:0] word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sfia_pkg::SlotW-1:0]        tri_index,
  output logic [sfia_pkg::SlotW-1:0]        vertex_slot,
  output logic [sfia_pkg::RefW-1:0]         position_ref,
  output logic [sfia_pkg::RefW-1:0]         normal_ref,
  output logic signed [sfia_pkg::TexW-1:0]  tex_u,
  output logic signed [sfia_pkg::TexW-1:0]  tex_v,
  output logic                              last,
  output logic                              list_end,
  output logic [sfia_pkg::CountW-1:0]       index_total,
  output logic                              overflow
);

  logic                            accept;
  logic                            push;
  sfia_pkg::rec_t                  push_rec;
  logic                            pop;
  sfia_pkg::rec_t                  head;
  logic                            head_valid;
  logic                            full;
  logic [sfia_pkg::QueuePtrW:0]    q_count;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // Word parser and vertex record builder.
  sfia_decode #(
    .MAX_VERTS(MAX_VERTS)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .word     (word),
    .push     (push),
    .rec      (push_rec)
  );

  // Record queue.
  sfia_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .full      (full),
    .count     (q_count)
  );

  // Index serializer and output register.
  sfia_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tri_index   (tri_index),
    .vertex_slot (vertex_slot),
    .position_ref(position_ref),
    .normal_ref  (normal_ref),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .last        (last),
    .list_end    (list_end),
    .index_total (index_total),
    .overflow    (overflow)
  );

  // The queue never holds more records than it has entries.
  `SFIA_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, q_count <= 3'(sfia_pkg::QueueDepth))

  // A terminator result is always the final result of its word.
  `SFIA_ASSERT_NOW(a_end_is_last, clk, rst, out_valid && list_end, last)

  // The remaining indices of a vertex follow without a gap.
  `SFIA_ASSERT_NEXT(a_tri_follows, clk, rst, out_valid && !out_stall && !last, out_valid)

endmodule
